// ===== sv/decimal_prefix_remainder_macros.svh =====
// Assertion macros for the decimal prefix remainder block.
// Needs aclk and aresetn in the scope of each use.
`ifndef DECIMAL_PREFIX_REMAINDER_MACROS_SVH
`define DECIMAL_PREFIX_REMAINDER_MACROS_SVH

// Same-cycle implication.
`define DPR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dpr assertion failed");

// Next-cycle implication.
`define DPR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dpr assertion failed");

`endif

// ===== sv/dpr_pkg.sv =====
// Shared types and constants for the decimal prefix remainder block.
// No dependencies.
`timescale 1ns / 1ps

package dpr_pkg;

    localparam int DIGIT_W  = 4;
    localparam int MOD_W    = 52;
    localparam int COUNT_W  = 24;
    localparam int ACC_W    = MOD_W + 4;
    localparam int IDX_W    = $clog2(ACC_W);

    localparam logic [MOD_W-1:0]   MODULUS_RESET  = MOD_W'(3);
    localparam logic [COUNT_W-1:0] MAX_LENGTH_DEF = COUNT_W'(8388608);

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } dpr_in_t;

    typedef struct packed {
        logic [MOD_W-1:0]   remainder;
        logic [COUNT_W-1:0] prefix_length;
        logic               divides;
        logic               end_of_term;
    } dpr_out_t;

    typedef struct packed {
        logic start;
        logic ack;
    } dpr_ctl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } dpr_sts_t;

endpackage

// ===== sv/decimal_prefix_remainder.sv =====
// Top level: decimal prefix remainder, Horner rule r = (10r + d) mod p per digit.
// Depends on dpr_pkg, dpr_mod_unit and decimal_prefix_remainder_macros.svh.
//
//  channel | ports               | beat
//  --------+---------------------+-------------------------------------------
//  input   | s_valid/s_ready     | s_data: digit, last
//  result  | m_valid/m_ready     | m_data: remainder, prefix_length, divides,
//          |                     |         end_of_term
//  config  | cfg_wr_en           | cfg_wr_data: modulus
//
// A digit passes accept, setup, four subtract steps and result load before the next is taken.
// With a zero modulus, or after a modulus change that leaves the stored remainder
// too large, the subtract unit runs over all 56 bits of 10r + d instead.
// Synchronous active-low reset clears state; modulus resets to 3.
// A held result stalls the unit in its done state; s_ready is low while busy.
`timescale 1ns / 1ps
`include "decimal_prefix_remainder_macros.svh"

module decimal_prefix_remainder #(
    parameter logic [dpr_pkg::COUNT_W-1:0] MAX_LENGTH = dpr_pkg::MAX_LENGTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  dpr_pkg::dpr_in_t          s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output dpr_pkg::dpr_out_t         m_data,
    input  logic                      cfg_wr_en,
    input  logic [dpr_pkg::MOD_W-1:0] cfg_wr_data
);

    logic [dpr_pkg::MOD_W-1:0]   mod_reg;
    logic [dpr_pkg::MOD_W-1:0]   rem_reg,     rem_next;
    logic [dpr_pkg::COUNT_W-1:0] len_reg,     len_next;
    logic [dpr_pkg::COUNT_W-1:0] item_len_reg, item_len_next;
    logic                        item_last_reg, item_last_next;
    logic                        m_valid_reg, m_valid_next;
    dpr_pkg::dpr_out_t           m_data_reg,  m_data_next;

    dpr_pkg::dpr_ctl_t           ctl;
    dpr_pkg::dpr_sts_t           sts;
    logic [dpr_pkg::ACC_W-1:0]   acc;
    logic [dpr_pkg::MOD_W-1:0]   unit_rem;
    logic                        accept;
    logic                        load;

    assign s_ready = sts.idle;
    assign accept  = s_valid && s_ready;
    assign load    = sts.done && (!m_valid_reg || m_ready);

    assign acc = ({4'd0, rem_reg} << 3) + ({4'd0, rem_reg} << 1)
               + {{dpr_pkg::MOD_W{1'b0}}, s_data.digit};

    assign ctl.start = accept;
    assign ctl.ack   = load;

    dpr_mod_unit u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .acc     (acc),
        .modulus (mod_reg),
        .sts     (sts),
        .rem     (unit_rem)
    );

    always_comb begin
        rem_next       = rem_reg;
        len_next       = len_reg;
        item_len_next  = item_len_reg;
        item_last_next = item_last_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            item_len_next  = (len_reg < MAX_LENGTH) ? len_reg + 1'b1 : MAX_LENGTH;
            item_last_next = s_data.last;
        end
        if (load) begin
            m_valid_next              = 1'b1;
            m_data_next.remainder     = unit_rem;
            m_data_next.prefix_length = item_len_reg;
            m_data_next.divides       = unit_rem == '0;
            m_data_next.end_of_term   = item_last_reg;
            rem_next                  = item_last_reg ? '0 : unit_rem;
            len_next                  = item_last_reg ? '0 : item_len_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg     <= dpr_pkg::MODULUS_RESET;
            rem_reg     <= '0;
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mod_reg <= cfg_wr_data;
            end
            rem_reg     <= rem_next;
            len_reg     <= len_next;
            m_valid_reg <= m_valid_next;
        end
        item_len_reg  <= item_len_next;
        item_last_reg <= item_last_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `DPR_ASSERT_NXT(a_busy_after_accept, accept, !s_ready)
    `DPR_ASSERT_IMP(a_rem_below_mod, m_valid && (mod_reg > dpr_pkg::MOD_W'(1)), m_data.remainder < mod_reg)
    `DPR_ASSERT_NXT(a_term_clears, load && item_last_reg, (rem_reg == '0) && (len_reg == '0))
    `DPR_ASSERT_IMP(a_len_bounded, m_valid, (m_data.prefix_length <= MAX_LENGTH) && (m_data.prefix_length != '0))

endmodule

// ===== sv/dpr_mod_unit.sv =====
// Iterative remainder unit: acc mod p by one conditional shifted subtract a cycle.
// Depends on dpr_pkg.
`timescale 1ns / 1ps

module dpr_mod_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  dpr_pkg::dpr_ctl_t         ctl,
    input  logic [dpr_pkg::ACC_W-1:0] acc,
    input  logic [dpr_pkg::MOD_W-1:0] modulus,
    output dpr_pkg::dpr_sts_t         sts,
    output logic [dpr_pkg::MOD_W-1:0] rem
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t                      state_reg;
    logic [dpr_pkg::ACC_W-1:0]   acc_reg;
    logic [dpr_pkg::MOD_W-1:0]   p_reg;
    logic [dpr_pkg::MOD_W-1:0]   r_reg;
    logic [dpr_pkg::IDX_W-1:0]   idx_reg;
    logic                        zero_reg;

    logic [dpr_pkg::MOD_W:0]     trial;
    logic [dpr_pkg::MOD_W+1:0]   diff;
    logic                        fast;

    // shared shift-subtract step
    assign trial = {r_reg, acc_reg[idx_reg]};
    assign diff  = {1'b0, trial} - {2'b00, p_reg};
    assign fast  = acc_reg[dpr_pkg::ACC_W-1:4] < p_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (ctl.start) begin
                        acc_reg   <= acc;
                        p_reg     <= modulus;
                        zero_reg  <= modulus < dpr_pkg::MOD_W'(2);
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    if (fast) begin
                        r_reg   <= acc_reg[dpr_pkg::ACC_W-1:4];
                        idx_reg <= dpr_pkg::IDX_W'(3);
                    end else begin
                        r_reg   <= '0;
                        idx_reg <= dpr_pkg::IDX_W'(dpr_pkg::ACC_W - 1);
                    end
                    state_reg <= ST_RUN;
                end
                ST_RUN: begin
                    if (diff[dpr_pkg::MOD_W+1]) begin
                        r_reg <= trial[dpr_pkg::MOD_W-1:0];
                    end else begin
                        r_reg <= diff[dpr_pkg::MOD_W-1:0];
                    end
                    if (idx_reg == '0) begin
                        state_reg <= ST_DONE;
                    end else begin
                        idx_reg <= idx_reg - 1'b1;
                    end
                end
                ST_DONE: begin
                    if (ctl.ack) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign sts.idle = state_reg == ST_IDLE;
    assign sts.done = state_reg == ST_DONE;
    assign rem      = zero_reg ? '0 : r_reg;

endmodule

// ===== tb/tb_decimal_prefix_remainder.sv =====
// Self-checking bench for decimal_prefix_remainder: feeds digit beats with random gaps,
// predicts each Horner remainder beat and checks it against the result channel.
// Depends on dpr_pkg and the decimal_prefix_remainder RTL.
`timescale 1ns / 1ps

module tb_decimal_prefix_remainder;
    import dpr_pkg::*;

    localparam int LEN_CAP     = int'(MAX_LENGTH_DEF);
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 64;
    localparam logic [MOD_W-1:0] MOD_TOP = '1;

    class prefix_scoreboard;
        logic [MOD_W-1:0]   modulus;
        logic [MOD_W-1:0]   rem;
        logic [COUNT_W-1:0] count;
        dpr_out_t           pending[$];
        int                 errors;

        function new();
            modulus = MODULUS_RESET;
            rem     = '0;
            count   = '0;
            errors  = 0;
        endfunction

        function void note_digit(dpr_in_t beat);
            logic [ACC_W-1:0] acc;
            dpr_out_t         want;
            acc = ACC_W'(rem) * ACC_W'(10) + ACC_W'(beat.digit);
            if (modulus < MOD_W'(2)) begin
                want.remainder = '0;
            end else begin
                want.remainder = MOD_W'(acc % ACC_W'(modulus));
            end
            count              = (count < COUNT_W'(LEN_CAP)) ? count + 1'b1 : COUNT_W'(LEN_CAP);
            want.prefix_length = count;
            want.divides       = (want.remainder == '0);
            want.end_of_term   = beat.last;
            pending.push_back(want);
            if (beat.last) begin
                rem   = '0;
                count = '0;
            end else begin
                rem = want.remainder;
            end
        endfunction

        function void check_result(dpr_out_t got);
            dpr_out_t want;
            if (pending.size() == 0) begin
                $display("%0t: result beat with no digit outstanding: rem=%0d len=%0d",
                         $time, got.remainder, got.prefix_length);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.remainder !== want.remainder || got.prefix_length !== want.prefix_length ||
                got.divides !== want.divides || got.end_of_term !== want.end_of_term) begin
                $display("%0t: mismatch: expected rem=%0d len=%0d div=%b eot=%b", $time,
                         want.remainder, want.prefix_length, want.divides, want.end_of_term);
                $display("%0t:           actual   rem=%0d len=%0d div=%b eot=%b", $time,
                         got.remainder, got.prefix_length, got.divides, got.end_of_term);
                errors++;
            end
        endfunction
    endclass

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    dpr_in_t          s_data;
    logic             m_valid;
    logic             m_ready;
    dpr_out_t         m_data;
    logic             cfg_wr_en;
    logic [MOD_W-1:0] cfg_wr_data;

    prefix_scoreboard board = new();
    int               idle_pct  = 34;
    int               stall_pct = 34;
    int               term_left = 0;
    int               cycles    = 0;

    decimal_prefix_remainder #(
        .MAX_LENGTH(COUNT_W'(LEN_CAP))
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("decimal_prefix_remainder regression: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_result(m_data);
        end
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic push_digit(input logic [DIGIT_W-1:0] d, input logic fin);
        dpr_in_t beat;
        beat.digit = d;
        beat.last  = fin;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        board.note_digit(beat);
    endtask

    // drain every outstanding beat, then write the register
    task automatic load_modulus(input logic [MOD_W-1:0] value);
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.pending.size() != 0);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        board.modulus = value;
    endtask

    task automatic push_random();
        logic [DIGIT_W-1:0] d;
        logic               fin;
        if (term_left == 0) begin
            term_left = ($urandom_range(99) < 20) ? $urandom_range(24, 13) : $urandom_range(10, 1);
        end
        d   = ($urandom_range(99) < 6) ? DIGIT_W'($urandom_range(15, 10))
                                       : DIGIT_W'($urandom_range(9, 0));
        fin = (term_left == 1) || ($urandom_range(99) < 3);
        term_left = fin ? 0 : term_left - 1;
        push_digit(d, fin);
    endtask

    initial begin
        logic [MOD_W-1:0] plan [10];
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        push_digit(4'd9, 1'b0);
        push_digit(4'd9, 1'b0);
        push_digit(4'd9, 1'b1);
        push_digit(4'd0, 1'b1);
        push_digit(4'd15, 1'b0);
        push_digit(4'd10, 1'b1);
        load_modulus('0);
        push_digit(4'd7, 1'b0);
        push_digit(4'd15, 1'b1);
        load_modulus(MOD_W'(1));
        push_digit(4'd5, 1'b1);
        load_modulus(MOD_TOP);
        repeat (15) push_digit(4'd9, 1'b0);
        // shrink the modulus under an open term
        load_modulus(MOD_W'(7));
        push_digit(4'd3, 1'b1);

        plan[0] = MOD_W'(2);
        plan[1] = MOD_W'(10);
        plan[2] = MOD_TOP;
        plan[3] = MOD_TOP - 1'b1;
        plan[4] = {20'($urandom), 32'($urandom)};
        plan[5] = '0;
        plan[6] = MOD_W'(1);
        plan[7] = MOD_W'($urandom_range(1000, 2));
        plan[8] = MOD_W'(9);
        plan[9] = {20'($urandom), 32'($urandom)};
        for (int p = 0; p < 10; p++) begin
            load_modulus(plan[p]);
            idle_pct  = (p == 2) ? 0 : 34;
            stall_pct = (p == 2) ? 0 : 34;
            repeat ((p == 2) ? 150 : 100) push_random();
        end

        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("decimal_prefix_remainder regression: pass");
        end else begin
            $display("decimal_prefix_remainder regression: fail");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/dpr_pkg.sv
sv/dpr_mod_unit.sv
sv/decimal_prefix_remainder.sv
tb/tb_decimal_prefix_remainder.sv
